/* hw/rtl/multi_slot_timer_table_core_assert.svh */
// assertion macros shared by the timer table rtl
`ifndef MULTI_SLOT_TIMER_TABLE_CORE_ASSERT_SVH
`define MULTI_SLOT_TIMER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define MSTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table check failed");

// next-cycle implication, ignored while reset is high
`define MSTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table check failed");

`endif

/* hw/rtl/mstt_pkg.sv */
package mstt_pkg;

   localparam int SLOTS_DEF     = 32;
   localparam int TIME_BITS_DEF = 48;
   localparam int MAX_RESULTS   = 32;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_QUERY  = 3'd4,
      CMD_TICK   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK    = 3'd0,
      STS_FULL  = 3'd1,
      STS_BAD   = 3'd2,
      STS_ZERO  = 3'd3,
      STS_FIRED = 3'd4,
      STS_NONE  = 3'd5
   } status_type;

endpackage

/* hw/rtl/multi_slot_timer_table_core.sv */
// stop, delete and unknown commands answer from decode; start answers from its write state,
//    query from its compare state; create scans upward for the lowest free slot, else reports full
// tick: advances the ms clock, then scans the slots, comparing each armed one with now; a due
//    periodic slot is reloaded and rechecked; the shared adder and one-port stores serialise this
// one command at a time: busy drops in the cycle of the last result, the receiver cannot stall
// reset: synchronous, clears slot flags and the ms clock; timer stores need no clearing
`include "multi_slot_timer_table_core_assert.svh"

module multi_slot_timer_table_core #(
   parameter int SLOTS     = mstt_pkg::SLOTS_DEF,
   parameter int TIME_BITS = mstt_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command side
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [4:0]  req_slot_index,
   input  logic [31:0] req_period_ms,
   input  logic        req_repeat_mode,
   input  logic [15:0] req_elapsed_ms,
   // result side, a one-cycle strobe per result, no back pressure
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_result_slot,
   output logic        rsp_is_active,
   output logic [31:0] rsp_remaining,
   output logic        rsp_last
);

   // slot index width, scan counter width (must reach SLOTS), and a width that holds both
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int IX_W   = (CNT_W > 5) ? CNT_W : 5;
   localparam int FIRE_W = $clog2(mstt_pkg::MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_CREATE,
      S_START,
      S_QUERY,
      S_TICK,
      S_SC_RD,
      S_SC_CMP,
      S_SC_ADD,
      S_SC_CHK,
      S_SC_RST,
      S_SC_END
   } state_type;

   // sequencer and command registers
   state_type            state_ff, state_in;
   mstt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [4:0]           slot_ff, slot_in;
   logic [31:0]          period_ff, period_in;
   logic                 rep_ff, rep_in;
   logic [15:0]          elapsed_ff, elapsed_in;

   // scan state
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [FIRE_W-1:0]    fire_ff, fire_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [TIME_BITS-1:0] acc_ff, acc_in;

   // table flags and ms clock
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SLOTS-1:0]     alloc_ff, alloc_in;
   logic [SLOTS-1:0]     armed_ff, armed_in;
   logic [SLOTS-1:0]     periodic_ff, periodic_in;

   // result registers
   logic                 rsp_strobe_ff, rsp_strobe_in;
   mstt_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [4:0]           rsp_slot_ff, rsp_slot_in;
   logic                 rsp_active_ff, rsp_active_in;
   logic [31:0]          rsp_remaining_ff, rsp_remaining_in;
   logic                 rsp_last_ff, rsp_last_in;

   // timer stores, one read and one write port each
   logic [31:0]          period_mem [SLOTS];
   logic [TIME_BITS-1:0] expiry_mem [SLOTS];
   logic [31:0]          rd_period_ff;
   logic [TIME_BITS-1:0] rd_expiry_ff;
   logic                 rd_en;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 wr_exp_en;
   logic                 wr_per_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [TIME_BITS-1:0] wr_exp_data;

   // shared adder / subtractor
   logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
   logic                 alu_sub, alu_carry;
   logic [TIME_BITS:0]   alu_sum;

   // command slot decode
   logic [IX_W-1:0]      idx_wide;
   logic [SLOT_W-1:0]    idx_sel;
   logic                 idx_valid;
   logic [SLOT_W-1:0]    cnt_sel;
   logic [31:0]          rem_sat;

   assign idx_wide  = IX_W'(slot_ff);
   assign idx_sel   = idx_wide[SLOT_W-1:0];
   assign idx_valid = (idx_wide < IX_W'(SLOTS)) && alloc_ff[idx_sel];
   assign cnt_sel   = cnt_ff[SLOT_W-1:0];

   // operand select for the single wide adder
   always_comb begin
      alu_a   = now_ff;
      alu_b   = TIME_BITS'(period_ff);
      alu_sub = 1'b0;
      case (state_ff)
         S_QUERY: begin
            alu_a   = rd_expiry_ff;
            alu_b   = now_ff;
            alu_sub = 1'b1;
         end
         S_TICK: begin
            alu_b = TIME_BITS'(elapsed_ff);
         end
         S_SC_CMP: begin
            alu_b   = rd_expiry_ff;
            alu_sub = 1'b1;
         end
         S_SC_ADD: begin
            alu_a = rd_expiry_ff;
            alu_b = TIME_BITS'(rd_period_ff);
         end
         S_SC_CHK: begin
            alu_a   = acc_ff;
            alu_b   = now_ff;
            alu_sub = 1'b1;
         end
         S_SC_RST: begin
            alu_b = TIME_BITS'(rd_period_ff);
         end
         default: begin
         end
      endcase
   end

   // carry out of a subtract means a >= b; the sum wraps modulo 2^TIME_BITS
   assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + (TIME_BITS + 1)'(alu_sub);
   assign alu_res   = alu_sum[TIME_BITS-1:0];
   assign alu_carry = alu_sum[TIME_BITS];

   // remaining time saturates to 32 bits
   assign rem_sat = (|alu_res[TIME_BITS-1:32]) ? '1 : alu_res[31:0];

   assign rd_addr = (state_ff == S_DECODE) ? idx_sel : cnt_sel;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      period_in     = period_ff;
      rep_in        = rep_ff;
      elapsed_in    = elapsed_ff;
      cnt_in        = cnt_ff;
      fire_in       = fire_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      acc_in        = acc_ff;
      now_in        = now_ff;
      alloc_in      = alloc_ff;
      armed_in      = armed_ff;
      periodic_in   = periodic_ff;

      rsp_strobe_in    = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_active_in    = rsp_active_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rsp_last_in      = rsp_last_ff;

      rd_en       = 1'b0;
      wr_exp_en   = 1'b0;
      wr_per_en   = 1'b0;
      wr_addr     = cnt_sel;
      wr_exp_data = alu_res;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = mstt_pkg::cmd_type'(req_cmd);
               slot_in    = req_slot_index;
               period_in  = req_period_ms;
               rep_in     = req_repeat_mode;
               elapsed_in = req_elapsed_ms;
               state_in   = S_DECODE;
            end
         end

         S_DECODE: begin
            // single-result answer by default; plain ok for unknown commands
            state_in         = S_IDLE;
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = mstt_pkg::STS_OK;
            rsp_slot_in      = '0;
            rsp_active_in    = 1'b0;
            rsp_remaining_in = '0;
            rsp_last_in      = 1'b1;
            unique case (cmd_ff) inside
               mstt_pkg::CMD_CREATE: begin
                  rsp_strobe_in = 1'b0;
                  cnt_in        = '0;
                  state_in      = S_CREATE;
               end
               mstt_pkg::CMD_START: begin
                  if (!idx_valid) begin
                     rsp_status_in = mstt_pkg::STS_BAD;
                  end else if (period_ff == '0) begin
                     rsp_status_in = mstt_pkg::STS_ZERO;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_START;
                  end
               end
               mstt_pkg::CMD_STOP, mstt_pkg::CMD_DELETE: begin
                  if (!idx_valid) begin
                     rsp_status_in = mstt_pkg::STS_BAD;
                  end else begin
                     armed_in[idx_sel] = 1'b0;
                     if (cmd_ff == mstt_pkg::CMD_DELETE) begin
                        alloc_in[idx_sel] = 1'b0;
                     end
                  end
               end
               mstt_pkg::CMD_QUERY: begin
                  if (!idx_valid) begin
                     rsp_status_in = mstt_pkg::STS_BAD;
                  end else begin
                     // fetch the expiry for the compare in the next cycle
                     rd_en         = 1'b1;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_QUERY;
                  end
               end
               mstt_pkg::CMD_TICK: begin
                  rsp_strobe_in = 1'b0;
                  state_in      = S_TICK;
               end
               default: begin
               end
            endcase
         end

         S_CREATE: begin
            // lowest free slot, one slot a cycle
            if (cnt_ff == CNT_W'(SLOTS)) begin
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = mstt_pkg::STS_FULL;
               rsp_slot_in      = '0;
               rsp_active_in    = 1'b0;
               rsp_remaining_in = '0;
               rsp_last_in      = 1'b1;
               state_in         = S_IDLE;
            end else if (!alloc_ff[cnt_sel]) begin
               alloc_in[cnt_sel]    = 1'b1;
               armed_in[cnt_sel]    = 1'b0;
               periodic_in[cnt_sel] = 1'b0;
               rsp_strobe_in        = 1'b1;
               rsp_status_in        = mstt_pkg::STS_OK;
               rsp_slot_in          = 5'(cnt_sel);
               rsp_active_in        = 1'b0;
               rsp_remaining_in     = '0;
               rsp_last_in          = 1'b1;
               state_in             = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_START: begin
            // expiry = now + period
            wr_exp_en            = 1'b1;
            wr_per_en            = 1'b1;
            wr_addr              = idx_sel;
            periodic_in[idx_sel] = rep_ff;
            armed_in[idx_sel]    = 1'b1;
            rsp_strobe_in        = 1'b1;
            rsp_status_in        = mstt_pkg::STS_OK;
            rsp_slot_in          = '0;
            rsp_active_in        = 1'b0;
            rsp_remaining_in     = '0;
            rsp_last_in          = 1'b1;
            state_in             = S_IDLE;
         end

         S_QUERY: begin
            // expiry - now: no borrow and nonzero means still in the future
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = mstt_pkg::STS_OK;
            rsp_slot_in      = slot_ff;
            rsp_active_in    = armed_ff[idx_sel];
            rsp_remaining_in = (armed_ff[idx_sel] && alu_carry && (alu_res != '0)) ?
                               rem_sat : '0;
            rsp_last_in      = 1'b1;
            state_in         = S_IDLE;
         end

         S_TICK: begin
            now_in        = alu_res;
            cnt_in        = '0;
            fire_in       = '0;
            pend_valid_in = 1'b0;
            state_in      = S_SC_RD;
         end

         S_SC_RD: begin
            if ((cnt_ff == CNT_W'(SLOTS)) || (fire_ff == FIRE_W'(mstt_pkg::MAX_RESULTS))) begin
               state_in = S_SC_END;
            end else if (alloc_ff[cnt_sel] && armed_ff[cnt_sel]) begin
               rd_en    = 1'b1;
               state_in = S_SC_CMP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_SC_CMP: begin
            // now - expiry without borrow: the slot has expired
            if (alu_carry) begin
               // the previous fired slot now known not to be the last
               if (pend_valid_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_status_in    = mstt_pkg::STS_FIRED;
                  rsp_slot_in      = 5'(pend_slot_ff);
                  rsp_active_in    = 1'b0;
                  rsp_remaining_in = '0;
                  rsp_last_in      = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = cnt_sel;
               fire_in       = fire_ff + 1'b1;
               if (periodic_ff[cnt_sel]) begin
                  state_in = S_SC_ADD;
               end else begin
                  armed_in[cnt_sel] = 1'b0;
                  cnt_in            = cnt_ff + 1'b1;
                  state_in          = S_SC_RD;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SC_RD;
            end
         end

         S_SC_ADD: begin
            acc_in   = alu_res;
            state_in = S_SC_CHK;
         end

         S_SC_CHK: begin
            // reloaded expiry not behind now: keep it, else restart from now + period
            if (alu_carry) begin
               wr_exp_en   = 1'b1;
               wr_exp_data = acc_ff;
               cnt_in      = cnt_ff + 1'b1;
               state_in    = S_SC_RD;
            end else begin
               state_in = S_SC_RST;
            end
         end

         S_SC_RST: begin
            wr_exp_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            state_in  = S_SC_RD;
         end

         S_SC_END: begin
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = pend_valid_ff ? mstt_pkg::STS_FIRED : mstt_pkg::STS_NONE;
            rsp_slot_in      = pend_valid_ff ? 5'(pend_slot_ff) : 5'd0;
            rsp_active_in    = 1'b0;
            rsp_remaining_in = '0;
            rsp_last_in      = 1'b1;
            pend_valid_in    = 1'b0;
            state_in         = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         fire_ff       <= '0;
         pend_valid_ff <= 1'b0;
         now_ff        <= '0;
         alloc_ff      <= '0;
         armed_ff      <= '0;
         periodic_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fire_ff       <= fire_in;
         pend_valid_ff <= pend_valid_in;
         now_ff        <= now_in;
         alloc_ff      <= alloc_in;
         armed_ff      <= armed_in;
         periodic_ff   <= periodic_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff           <= cmd_in;
      slot_ff          <= slot_in;
      period_ff        <= period_in;
      rep_ff           <= rep_in;
      elapsed_ff       <= elapsed_in;
      pend_slot_ff     <= pend_slot_in;
      acc_ff           <= acc_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_active_ff    <= rsp_active_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // timer stores, registered read
   always_ff @(posedge clock) begin
      if (wr_exp_en) begin
         expiry_mem[wr_addr] <= wr_exp_data;
      end
      if (wr_per_en) begin
         period_mem[wr_addr] <= period_ff;
      end
      if (rd_en) begin
         rd_expiry_ff <= expiry_mem[rd_addr];
         rd_period_ff <= period_mem[rd_addr];
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_is_active   = rsp_active_ff;
   assign rsp_remaining   = rsp_remaining_ff;
   assign rsp_last        = rsp_last_ff;

   // a transfer always starts the sequencer
   `MSTT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // the final result of a command leaves the block ready
   `MSTT_ASSERT_SAME(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)
   // only fired results are followed by more results
   `MSTT_ASSERT_SAME(a_more_fired, clock, reset, rsp_strobe && !rsp_last,
                     rsp_status == mstt_pkg::STS_FIRED)
   // an armed slot is always allocated
   `MSTT_ASSERT_SAME(a_armed_alloc, clock, reset, 1'b1, (armed_ff & ~alloc_ff) == '0)
   // fires per tick never exceed the result limit
   `MSTT_ASSERT_SAME(a_fire_cap, clock, reset, 1'b1,
                     fire_ff <= FIRE_W'(mstt_pkg::MAX_RESULTS))

endmodule
